// ===== design/mcfsm_pkg.sv =====
// package: control state codes, opcode and mode codes, item and result types
`timescale 1ns / 1ps

package mcfsm_pkg;

    localparam int STATE_W = 5;
    localparam int IN_TDATA_W = 16;
    localparam int OUT_TDATA_W = 8;

    // control state codes
    localparam logic [STATE_W-1:0] ST_FETCH       = 5'd1;
    localparam logic [STATE_W-1:0] ST_DECODE      = 5'd2;
    localparam logic [STATE_W-1:0] ST_OPERAND     = 5'd3;
    localparam logic [STATE_W-1:0] ST_STORE_A     = 5'd4;
    localparam logic [STATE_W-1:0] ST_STORE_B     = 5'd5;
    localparam logic [STATE_W-1:0] ST_STORE_C     = 5'd6;
    localparam logic [STATE_W-1:0] ST_ADDR_IND    = 5'd7;
    localparam logic [STATE_W-1:0] ST_STORE_IMM   = 5'd8;
    localparam logic [STATE_W-1:0] ST_ADDR_IDX    = 5'd9;
    localparam logic [STATE_W-1:0] ST_LOAD        = 5'd10;
    localparam logic [STATE_W-1:0] ST_ADDR_IDX2   = 5'd11;
    localparam logic [STATE_W-1:0] ST_ALU         = 5'd12;
    localparam logic [STATE_W-1:0] ST_UNARY       = 5'd13;
    localparam logic [STATE_W-1:0] ST_BRANCH      = 5'd14;
    localparam logic [STATE_W-1:0] ST_BRANCH_DIR  = 5'd15;
    localparam logic [STATE_W-1:0] ST_BRANCH_SKIP = 5'd16;
    localparam logic [STATE_W-1:0] ST_BRANCH_IDX  = 5'd17;
    localparam logic [STATE_W-1:0] ST_JSR_A       = 5'd18;
    localparam logic [STATE_W-1:0] ST_JSR_B       = 5'd19;
    localparam logic [STATE_W-1:0] ST_JSR_C       = 5'd20;
    localparam logic [STATE_W-1:0] ST_JSR_D       = 5'd21;
    localparam logic [STATE_W-1:0] ST_JSR_IDX     = 5'd22;
    localparam logic [STATE_W-1:0] ST_ADDR_IND2   = 5'd23;

    // opcodes
    localparam logic [3:0] OP_NOP = 4'd0;
    localparam logic [3:0] OP_STR = 4'd1;
    localparam logic [3:0] OP_LDR = 4'd2;
    localparam logic [3:0] OP_ADD = 4'd3;
    localparam logic [3:0] OP_OR  = 4'd4;
    localparam logic [3:0] OP_AND = 4'd5;
    localparam logic [3:0] OP_NOT = 4'd6;
    localparam logic [3:0] OP_SUB = 4'd7;
    localparam logic [3:0] OP_JMP = 4'd8;
    localparam logic [3:0] OP_JN  = 4'd9;
    localparam logic [3:0] OP_JZ  = 4'd10;
    localparam logic [3:0] OP_JC  = 4'd11;
    localparam logic [3:0] OP_JSR = 4'd12;
    localparam logic [3:0] OP_NEG = 4'd13;
    localparam logic [3:0] OP_SHR = 4'd14;
    localparam logic [3:0] OP_HLT = 4'd15;

    // addressing modes
    localparam logic [1:0] MODE_DIRECT    = 2'd0;
    localparam logic [1:0] MODE_INDIRECT  = 2'd1;
    localparam logic [1:0] MODE_IMMEDIATE = 2'd2;
    localparam logic [1:0] MODE_INDEXED   = 2'd3;

    // input item, opcode in the lowest bits
    typedef struct packed {
        logic       flag_carry;
        logic       flag_zero;
        logic       flag_negative;
        logic [1:0] address_mode;
        logic [3:0] opcode;
    } mcfsm_item_t;

    // result item, next_state in the lowest bits
    typedef struct packed {
        logic               halted;
        logic [STATE_W-1:0] next_state;
    } mcfsm_result_t;

    // step decision from the next-state logic
    typedef struct packed {
        logic [STATE_W-1:0] next_state;
        logic               halt_set;
    } mcfsm_step_t;

endpackage

// ===== design/mcfsm_next_state.sv =====
// combinational next-state logic of the control sequencer
`timescale 1ns / 1ps

module mcfsm_next_state (
    input  logic [mcfsm_pkg::STATE_W-1:0] state,
    input  logic                          halt,
    input  mcfsm_pkg::mcfsm_item_t        item,
    output mcfsm_pkg::mcfsm_step_t        step
);

    logic [3:0] op;
    logic [1:0] md;
    logic       alu;
    logic       cond_taken;
    logic       cond_not_taken;
    logic       taken;
    logic [mcfsm_pkg::STATE_W-1:0] adv;
    logic       hlt_hit;

    assign op = item.opcode;
    assign md = item.address_mode;

    assign alu = (op == mcfsm_pkg::OP_ADD) || (op == mcfsm_pkg::OP_SUB)
              || (op == mcfsm_pkg::OP_AND) || (op == mcfsm_pkg::OP_OR);
    assign cond_taken = (op == mcfsm_pkg::OP_JN && item.flag_negative)
                     || (op == mcfsm_pkg::OP_JZ && item.flag_zero)
                     || (op == mcfsm_pkg::OP_JC && item.flag_carry);
    assign cond_not_taken = (op == mcfsm_pkg::OP_JN && !item.flag_negative)
                         || (op == mcfsm_pkg::OP_JZ && !item.flag_zero)
                         || (op == mcfsm_pkg::OP_JC && !item.flag_carry);
    assign taken = cond_taken || (op == mcfsm_pkg::OP_JMP);

    always_comb
    begin
        adv     = mcfsm_pkg::ST_FETCH;
        hlt_hit = 1'b0;
        unique case (state) inside
            mcfsm_pkg::ST_FETCH:
            begin
                adv = mcfsm_pkg::ST_DECODE;
            end
            mcfsm_pkg::ST_DECODE:
            begin
                if (op == mcfsm_pkg::OP_NOT || op == mcfsm_pkg::OP_NEG
                    || op == mcfsm_pkg::OP_SHR)
                    adv = mcfsm_pkg::ST_UNARY;
                else if (cond_not_taken)
                    adv = mcfsm_pkg::ST_BRANCH_SKIP;
                else if (md == mcfsm_pkg::MODE_IMMEDIATE
                         && (taken || op == mcfsm_pkg::OP_JSR))
                    adv = mcfsm_pkg::ST_BRANCH_SKIP;
                else if (taken)
                    adv = mcfsm_pkg::ST_BRANCH;
                else if (op == mcfsm_pkg::OP_NOP)
                    adv = mcfsm_pkg::ST_FETCH;
                else if (op == mcfsm_pkg::OP_HLT)
                begin
                    adv     = mcfsm_pkg::ST_DECODE;
                    hlt_hit = 1'b1;
                end
                else
                    adv = mcfsm_pkg::ST_OPERAND;
            end
            mcfsm_pkg::ST_OPERAND:
            begin
                if (md == mcfsm_pkg::MODE_IMMEDIATE && op == mcfsm_pkg::OP_LDR)
                    adv = mcfsm_pkg::ST_LOAD;
                else if (md == mcfsm_pkg::MODE_IMMEDIATE && alu)
                    adv = mcfsm_pkg::ST_ALU;
                else if (md == mcfsm_pkg::MODE_INDIRECT)
                    adv = mcfsm_pkg::ST_ADDR_IND;
                else if (md == mcfsm_pkg::MODE_DIRECT && (op == mcfsm_pkg::OP_LDR || alu))
                    adv = mcfsm_pkg::ST_ADDR_IND;
                else if (md == mcfsm_pkg::MODE_INDEXED
                         && (op == mcfsm_pkg::OP_STR || op == mcfsm_pkg::OP_LDR || alu))
                    adv = mcfsm_pkg::ST_ADDR_IDX;
                else if (md == mcfsm_pkg::MODE_IMMEDIATE && op == mcfsm_pkg::OP_STR)
                    adv = mcfsm_pkg::ST_STORE_IMM;
                else if (md == mcfsm_pkg::MODE_DIRECT && op == mcfsm_pkg::OP_STR)
                    adv = mcfsm_pkg::ST_STORE_A;
                else if (md == mcfsm_pkg::MODE_DIRECT && op == mcfsm_pkg::OP_JSR)
                    adv = mcfsm_pkg::ST_JSR_A;
                else if (md == mcfsm_pkg::MODE_INDEXED && op == mcfsm_pkg::OP_JSR)
                    adv = mcfsm_pkg::ST_JSR_IDX;
                else if (taken)
                    adv = mcfsm_pkg::ST_BRANCH_DIR;
                else
                    adv = mcfsm_pkg::ST_FETCH;
            end
            mcfsm_pkg::ST_STORE_A:
            begin
                adv = mcfsm_pkg::ST_STORE_B;
            end
            mcfsm_pkg::ST_STORE_B:
            begin
                adv = mcfsm_pkg::ST_STORE_C;
            end
            mcfsm_pkg::ST_ADDR_IND:
            begin
                if (md == mcfsm_pkg::MODE_DIRECT && alu)
                    adv = mcfsm_pkg::ST_ALU;
                else if (md == mcfsm_pkg::MODE_DIRECT && op == mcfsm_pkg::OP_LDR)
                    adv = mcfsm_pkg::ST_LOAD;
                else if (op == mcfsm_pkg::OP_JSR)
                    adv = mcfsm_pkg::ST_JSR_A;
                else if (op == mcfsm_pkg::OP_STR)
                    adv = mcfsm_pkg::ST_STORE_A;
                else if (op == mcfsm_pkg::OP_LDR || alu)
                    adv = mcfsm_pkg::ST_ADDR_IND2;
                else
                    adv = mcfsm_pkg::ST_FETCH;
            end
            mcfsm_pkg::ST_STORE_IMM:
            begin
                adv = mcfsm_pkg::ST_STORE_B;
            end
            mcfsm_pkg::ST_ADDR_IDX:
            begin
                if (op == mcfsm_pkg::OP_STR)
                    adv = mcfsm_pkg::ST_STORE_B;
                else if (op == mcfsm_pkg::OP_LDR || alu)
                    adv = mcfsm_pkg::ST_ADDR_IDX2;
                else
                    adv = mcfsm_pkg::ST_FETCH;
            end
            mcfsm_pkg::ST_ADDR_IDX2, mcfsm_pkg::ST_ADDR_IND2:
            begin
                if (op == mcfsm_pkg::OP_LDR)
                    adv = mcfsm_pkg::ST_LOAD;
                else if (alu)
                    adv = mcfsm_pkg::ST_ALU;
                else
                    adv = mcfsm_pkg::ST_FETCH;
            end
            mcfsm_pkg::ST_BRANCH:
            begin
                if (md == mcfsm_pkg::MODE_DIRECT)
                    adv = mcfsm_pkg::ST_BRANCH_DIR;
                else if (md == mcfsm_pkg::MODE_INDIRECT)
                    adv = mcfsm_pkg::ST_ADDR_IND;
                else if (md == mcfsm_pkg::MODE_INDEXED)
                    adv = mcfsm_pkg::ST_BRANCH_IDX;
                else
                    adv = mcfsm_pkg::ST_FETCH;
            end
            mcfsm_pkg::ST_JSR_A:
            begin
                adv = mcfsm_pkg::ST_JSR_B;
            end
            mcfsm_pkg::ST_JSR_B:
            begin
                adv = mcfsm_pkg::ST_JSR_C;
            end
            mcfsm_pkg::ST_JSR_C:
            begin
                adv = mcfsm_pkg::ST_JSR_D;
            end
            mcfsm_pkg::ST_JSR_IDX:
            begin
                adv = mcfsm_pkg::ST_JSR_B;
            end
            default:
            begin
                adv = mcfsm_pkg::ST_FETCH;
            end
        endcase
    end

    // a latched halt freezes the state
    always_comb
    begin
        if (halt)
        begin
            step.next_state = state;
            step.halt_set   = 1'b0;
        end
        else
        begin
            step.next_state = adv;
            step.halt_set   = hlt_hit;
        end
    end

endmodule

// ===== design/multicycle_cpu_control_fsm.sv =====
// top level: stream wrapper around the multicycle cpu control sequencer
`timescale 1ns / 1ps

// usage
//   s_* channel: one transaction per processor tick, carrying the decoded
//     opcode, addressing mode and the n, z, c flags of that tick
//   m_* channel: one transaction per input transaction, carrying the control
//     state entered after that tick and the sticky halt flag
//   path: the input transaction passes through the input register, then the
//     result register, before m_tvalid rises for its result
//   throughput: one transaction per cycle while m_tready stays high; the
//     control state register updates on each tick moved to the result stage
//   reset: rst_n low clears both stages, puts the control state at fetch
//     and clears the halt flag
//   stall: while m_tready is low the result holds; the input register still
//     takes one more transaction, then s_tready drops until the result moves
//   once hlt is decoded every later result repeats the frozen state with
//     halted set, until reset

module multicycle_cpu_control_fsm (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // opcode[3:0], address_mode[5:4], flag_negative[6], flag_zero[7],
    // flag_carry[8], zero fill [15:9]
    input  logic [mcfsm_pkg::IN_TDATA_W-1:0]      s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // next_state[4:0], halted[5], zero fill [7:6]
    output logic [mcfsm_pkg::OUT_TDATA_W-1:0]     m_tdata
);

    localparam int ITEM_W = $bits(mcfsm_pkg::mcfsm_item_t);
    localparam int RES_W  = $bits(mcfsm_pkg::mcfsm_result_t);

    // input stage
    logic                           in_valid_reg;
    logic                           in_valid_next;
    mcfsm_pkg::mcfsm_item_t         in_item_reg;

    // result stage
    logic                           out_valid_reg;
    logic                           out_valid_next;
    mcfsm_pkg::mcfsm_result_t       out_result_reg;
    mcfsm_pkg::mcfsm_result_t       out_result_next;

    // sequencer state
    logic [mcfsm_pkg::STATE_W-1:0]  state_reg;
    logic [mcfsm_pkg::STATE_W-1:0]  state_next;
    logic                           halt_reg;
    logic                           halt_next;

    logic                           s_fire;
    logic                           advance;
    mcfsm_pkg::mcfsm_step_t         step;

    // a tick moves on when the result stage is empty or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    mcfsm_next_state u_next_state (
        .state (state_reg),
        .halt  (halt_reg),
        .item  (in_item_reg),
        .step  (step)
    );

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        state_next     = state_reg;
        halt_next      = halt_reg;
        if (advance)
        begin
            state_next = step.next_state;
            halt_next  = halt_reg | step.halt_set;
        end
        if (s_fire)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        if (advance)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        out_result_next.next_state = state_next;
        out_result_next.halted     = halt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= mcfsm_pkg::ST_FETCH;
            halt_reg      <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
            halt_reg      <= halt_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s_fire)
            in_item_reg <= mcfsm_pkg::mcfsm_item_t'(s_tdata[ITEM_W-1:0]);
        if (advance)
            out_result_reg <= out_result_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(mcfsm_pkg::OUT_TDATA_W - RES_W){1'b0}}, out_result_reg};

endmodule

// ===== design/mcfsm_checker.sv =====
// checker on the top-level ports of the control sequencer, with its bind
`timescale 1ns / 1ps

module mcfsm_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [mcfsm_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    logic                           m_fire;
    logic [mcfsm_pkg::STATE_W-1:0]  last_state_reg;
    logic                           last_halt_reg;

    assign m_fire = m_tvalid && m_tready;

    // state and halt flag of the last result transaction, fetch after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_state_reg <= mcfsm_pkg::ST_FETCH;
            last_halt_reg  <= 1'b0;
        end
        else if (m_fire)
        begin
            last_state_reg <= m_tdata[mcfsm_pkg::STATE_W-1:0];
            last_halt_reg  <= m_tdata[mcfsm_pkg::STATE_W];
        end
    end

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");

    // once halted, every later result repeats the frozen state
    a_halt_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        (m_fire && last_halt_reg) |->
        (m_tdata[mcfsm_pkg::STATE_W]
         && m_tdata[mcfsm_pkg::STATE_W-1:0] == last_state_reg))
        else $error("halt not sticky or state moved after halt");

    // halt is first reported in the decode state
    a_halt_in_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (m_fire && !last_halt_reg && m_tdata[mcfsm_pkg::STATE_W]) |->
        (m_tdata[mcfsm_pkg::STATE_W-1:0] == mcfsm_pkg::ST_DECODE))
        else $error("halt reported outside decode");

    // fetch is always followed by decode
    a_fetch_to_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (m_fire && !last_halt_reg && last_state_reg == mcfsm_pkg::ST_FETCH) |->
        (m_tdata[mcfsm_pkg::STATE_W-1:0] == mcfsm_pkg::ST_DECODE))
        else $error("fetch not followed by decode");

    // reported state is always a legal control state
    a_state_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |->
        (m_tdata[mcfsm_pkg::STATE_W-1:0] != '0
         && m_tdata[mcfsm_pkg::STATE_W-1:0] <= mcfsm_pkg::ST_ADDR_IND2))
        else $error("illegal control state on output");

endmodule

bind multicycle_cpu_control_fsm mcfsm_checker u_mcfsm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/tb_top.sv =====
// testbench for the multicycle cpu control sequencer: directed table, random instruction streams
`timescale 1ns / 1ps

module tb_top;

    import mcfsm_pkg::*;

    localparam int RANDOM_TICKS     = 1050;  // random ticks after the opening table
    localparam int CALM_TAIL        = 100;   // last random ticks run without idling
    localparam int LONG_HOLD        = 120;   // cycles the receiver backs off once
    localparam int WATCHDOG_LIMIT   = 2000;  // cycles with no transaction on either side
    localparam int SETTLE_CYCLES    = 8;     // covers the two pipeline stages with margin
    localparam int FROZEN_TICKS     = 16;    // ticks sent after hlt to check the freeze
    localparam int ITEM_W           = $bits(mcfsm_item_t);

    // one row of the opening sequence; nzc packs n, z, c from bit 2 down
    typedef struct packed {
        logic [3:0]         op;
        logic [1:0]         mode;
        logic [2:0]         nzc;
        logic               typed;
        logic               want_halt;
        logic [STATE_W-1:0] want_state;
    } opening_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;

    // predictor copy of the sequencer
    logic [STATE_W-1:0]     ctl_state;
    logic                   halt_seen;

    // control states still to come out of the block, oldest first
    mcfsm_result_t          pending_states[$];

    int                     errors;
    int                     idle_cycles;
    bit                     calm;
    bit                     long_hold_req;

    // walks the sequencer from reset through every opening special case
    opening_row_t opening_rows [28] = '{
        // state after reset: fetch always moves to decode
        '{OP_NOP, MODE_DIRECT,    3'b000, 1'b1, 1'b0, ST_DECODE},
        '{OP_NOP, MODE_DIRECT,    3'b000, 1'b1, 1'b0, ST_FETCH},
        // hlt outside decode means nothing, all fields at their top
        '{OP_HLT, MODE_INDEXED,   3'b111, 1'b1, 1'b0, ST_DECODE},
        '{OP_SHR, MODE_INDEXED,   3'b111, 1'b0, 1'b0, ST_FETCH},
        '{OP_NOT, MODE_IMMEDIATE, 3'b000, 1'b0, 1'b0, ST_FETCH},
        '{OP_NEG, MODE_DIRECT,    3'b000, 1'b0, 1'b0, ST_FETCH},
        // jn with n clear: branch not taken
        '{OP_JN,  MODE_DIRECT,    3'b000, 1'b0, 1'b0, ST_FETCH},
        '{OP_JN,  MODE_DIRECT,    3'b000, 1'b0, 1'b0, ST_FETCH},
        '{OP_JZ,  MODE_INDIRECT,  3'b010, 1'b0, 1'b0, ST_FETCH},
        // jz taken, indirect target chase
        '{OP_JZ,  MODE_INDIRECT,  3'b010, 1'b0, 1'b0, ST_FETCH},
        '{OP_JZ,  MODE_INDIRECT,  3'b010, 1'b0, 1'b0, ST_FETCH},
        '{OP_JZ,  MODE_INDIRECT,  3'b010, 1'b0, 1'b0, ST_FETCH},
        '{OP_JC,  MODE_IMMEDIATE, 3'b001, 1'b0, 1'b0, ST_FETCH},
        // jc taken with an immediate operand is skipped
        '{OP_JC,  MODE_IMMEDIATE, 3'b001, 1'b0, 1'b0, ST_FETCH},
        '{OP_JC,  MODE_IMMEDIATE, 3'b001, 1'b0, 1'b0, ST_FETCH},
        '{OP_JSR, MODE_INDEXED,   3'b000, 1'b0, 1'b0, ST_FETCH},
        // indexed subroutine call runs the whole call sequence
        '{OP_JSR, MODE_INDEXED,   3'b000, 1'b0, 1'b0, ST_FETCH},
        '{OP_JSR, MODE_INDEXED,   3'b000, 1'b0, 1'b0, ST_FETCH},
        '{OP_JSR, MODE_INDEXED,   3'b000, 1'b0, 1'b0, ST_FETCH},
        '{OP_JSR, MODE_INDEXED,   3'b000, 1'b0, 1'b0, ST_FETCH},
        '{OP_JSR, MODE_INDEXED,   3'b000, 1'b0, 1'b0, ST_FETCH},
        '{OP_JSR, MODE_INDEXED,   3'b000, 1'b0, 1'b0, ST_FETCH},
        '{OP_ADD, MODE_DIRECT,    3'b000, 1'b0, 1'b0, ST_FETCH},
        '{OP_ADD, MODE_DIRECT,    3'b000, 1'b0, 1'b0, ST_FETCH},
        // operand state with nop matches nothing and falls back to fetch
        '{OP_NOP, MODE_DIRECT,    3'b000, 1'b1, 1'b0, ST_FETCH},
        '{OP_JMP, MODE_DIRECT,    3'b000, 1'b1, 1'b0, ST_DECODE},
        '{OP_JMP, MODE_DIRECT,    3'b000, 1'b0, 1'b0, ST_FETCH},
        // branch state with an immediate operand matches nothing
        '{OP_JMP, MODE_IMMEDIATE, 3'b000, 1'b1, 1'b0, ST_FETCH}
    };

    multicycle_cpu_control_fsm u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // next control state for one tick, plus whether this tick latches the halt
    function automatic mcfsm_step_t sequencer_step(input logic [STATE_W-1:0] st,
                                                   input mcfsm_item_t it);
        logic        alu;
        logic        cond_hit;
        logic        cond_miss;
        logic        jumps;
        logic [3:0]  op;
        logic [1:0]  md;
        mcfsm_step_t r;
        op        = it.opcode;
        md        = it.address_mode;
        alu       = op inside {OP_ADD, OP_SUB, OP_AND, OP_OR};
        cond_hit  = (op == OP_JN && it.flag_negative) || (op == OP_JZ && it.flag_zero)
                    || (op == OP_JC && it.flag_carry);
        cond_miss = (op == OP_JN && !it.flag_negative) || (op == OP_JZ && !it.flag_zero)
                    || (op == OP_JC && !it.flag_carry);
        jumps     = cond_hit || op == OP_JMP;
        r.halt_set   = 1'b0;
        r.next_state = ST_FETCH;
        case (st)
            ST_FETCH:
                r.next_state = ST_DECODE;
            ST_DECODE:
                if (op inside {OP_NOT, OP_NEG, OP_SHR})
                    r.next_state = ST_UNARY;
                else if (cond_miss)
                    r.next_state = ST_BRANCH_SKIP;
                else if (md == MODE_IMMEDIATE && (jumps || op == OP_JSR))
                    r.next_state = ST_BRANCH_SKIP;
                else if (jumps)
                    r.next_state = ST_BRANCH;
                else if (op == OP_NOP)
                    r.next_state = ST_FETCH;
                else if (op == OP_HLT)
                begin
                    r.next_state = ST_DECODE;
                    r.halt_set   = 1'b1;
                end
                else
                    r.next_state = ST_OPERAND;
            ST_OPERAND:
                if (md == MODE_IMMEDIATE && op == OP_LDR)
                    r.next_state = ST_LOAD;
                else if (md == MODE_IMMEDIATE && alu)
                    r.next_state = ST_ALU;
                else if (md == MODE_INDIRECT)
                    r.next_state = ST_ADDR_IND;
                else if (md == MODE_DIRECT && (op == OP_LDR || alu))
                    r.next_state = ST_ADDR_IND;
                else if (md == MODE_INDEXED && (op == OP_STR || op == OP_LDR || alu))
                    r.next_state = ST_ADDR_IDX;
                else if (md == MODE_IMMEDIATE && op == OP_STR)
                    r.next_state = ST_STORE_IMM;
                else if (md == MODE_DIRECT && op == OP_STR)
                    r.next_state = ST_STORE_A;
                else if (md == MODE_DIRECT && op == OP_JSR)
                    r.next_state = ST_JSR_A;
                else if (md == MODE_INDEXED && op == OP_JSR)
                    r.next_state = ST_JSR_IDX;
                else if (jumps)
                    r.next_state = ST_BRANCH_DIR;
            ST_STORE_A:
                r.next_state = ST_STORE_B;
            ST_STORE_B:
                r.next_state = ST_STORE_C;
            ST_ADDR_IND:
                if (md == MODE_DIRECT && alu)
                    r.next_state = ST_ALU;
                else if (md == MODE_DIRECT && op == OP_LDR)
                    r.next_state = ST_LOAD;
                else if (op == OP_JSR)
                    r.next_state = ST_JSR_A;
                else if (op == OP_STR)
                    r.next_state = ST_STORE_A;
                else if (op == OP_LDR || alu)
                    r.next_state = ST_ADDR_IND2;
            ST_STORE_IMM:
                r.next_state = ST_STORE_B;
            ST_ADDR_IDX:
                if (op == OP_STR)
                    r.next_state = ST_STORE_B;
                else if (op == OP_LDR || alu)
                    r.next_state = ST_ADDR_IDX2;
            ST_ADDR_IDX2, ST_ADDR_IND2:
                if (op == OP_LDR)
                    r.next_state = ST_LOAD;
                else if (alu)
                    r.next_state = ST_ALU;
            ST_BRANCH:
                if (md == MODE_DIRECT)
                    r.next_state = ST_BRANCH_DIR;
                else if (md == MODE_INDIRECT)
                    r.next_state = ST_ADDR_IND;
                else if (md == MODE_INDEXED)
                    r.next_state = ST_BRANCH_IDX;
            ST_JSR_A:
                r.next_state = ST_JSR_B;
            ST_JSR_B:
                r.next_state = ST_JSR_C;
            ST_JSR_C:
                r.next_state = ST_JSR_D;
            ST_JSR_IDX:
                r.next_state = ST_JSR_B;
            default:
                r.next_state = ST_FETCH;
        endcase
        return r;
    endfunction

    // offers one tick on the input side, then books its expected result once taken
    task automatic send_tick(input mcfsm_item_t it, input bit typed,
                             input mcfsm_result_t typed_want);
        int            gap;
        mcfsm_step_t   step;
        mcfsm_result_t want;
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 19);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W - ITEM_W){1'b0}}, it};
        do
            @(posedge clk);
        while (!s_tready);
        // transaction taken: advance the predictor unless it is frozen
        if (!halt_seen)
        begin
            step      = sequencer_step(ctl_state, it);
            ctl_state = step.next_state;
            halt_seen = step.halt_set;
        end
        want.halted     = halt_seen;
        want.next_state = ctl_state;
        pending_states.push_back(typed ? typed_want : want);
        @(negedge clk);
    endtask

    // result side: random backpressure, one long hold-off on request
    initial
    begin
        int stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                stall_left    = LONG_HOLD;
            end
            else if (stall_left == 0 && !calm && $urandom_range(0, 9) == 0)
                stall_left = $urandom_range(1, 19);
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // result check against the oldest booked control state
    always @(posedge clk)
    begin
        mcfsm_result_t got;
        mcfsm_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = mcfsm_result_t'(m_tdata[$bits(mcfsm_result_t)-1:0]);
            if (pending_states.size() == 0)
            begin
                $display("%0t unexpected result: expected none actual state %0d halted %0d",
                         $time, got.next_state, got.halted);
                errors++;
            end
            else
            begin
                want = pending_states.pop_front();
                if (got.next_state !== want.next_state)
                begin
                    $display("%0t next_state mismatch: expected %0d actual %0d",
                             $time, want.next_state, got.next_state);
                    errors++;
                end
                if (got.halted !== want.halted)
                begin
                    $display("%0t halted mismatch: expected %0d actual %0d",
                             $time, want.halted, got.halted);
                    errors++;
                end
            end
        end
    end

    // watchdog: too long without any transaction means the block hung
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    initial
    begin
        mcfsm_item_t   item;
        mcfsm_result_t want;
        logic [3:0]    instr_op;
        logic [1:0]    instr_mode;
        int            ticks;
        bit            drained;
        bit            held;

        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        errors        = 0;
        idle_cycles   = 0;
        calm          = 1'b0;
        long_hold_req = 1'b0;
        ctl_state     = ST_FETCH;
        halt_seen     = 1'b0;
        instr_op      = OP_NOP;
        instr_mode    = MODE_DIRECT;
        ticks         = 0;
        drained       = 1'b0;
        held          = 1'b0;

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // opening table: typed expectations where obvious, predictor elsewhere
        foreach (opening_rows[i])
        begin
            item.opcode        = opening_rows[i].op;
            item.address_mode  = opening_rows[i].mode;
            item.flag_negative = opening_rows[i].nzc[2];
            item.flag_zero     = opening_rows[i].nzc[1];
            item.flag_carry    = opening_rows[i].nzc[0];
            want.halted        = opening_rows[i].want_halt;
            want.next_state    = opening_rows[i].want_state;
            send_tick(item, opening_rows[i].typed, want);
        end

        // random instruction streams: one instruction held from fetch until the
        // sequence returns to fetch, with some noise ticks that break it up
        while (ticks < RANDOM_TICKS)
        begin
            if (ctl_state == ST_FETCH)
            begin
                instr_op   = 4'($urandom_range(0, 14));
                instr_mode = 2'($urandom_range(0, 3));
            end
            item.opcode        = instr_op;
            item.address_mode  = instr_mode;
            item.flag_negative = 1'($urandom_range(0, 1));
            item.flag_zero     = 1'($urandom_range(0, 1));
            item.flag_carry    = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 99) < 15)
            begin
                item.opcode       = 4'($urandom_range(0, 15));
                item.address_mode = 2'($urandom_range(0, 3));
            end
            // hlt at decode freezes the block for good, so it waits for the end
            if (ctl_state == ST_DECODE && item.opcode == OP_HLT)
                item.opcode = 4'($urandom_range(0, 14));
            ticks++;
            if (ticks >= RANDOM_TICKS - CALM_TAIL)
                calm = 1'b1;

            // sender pause until the pipeline is empty
            if (!drained && ticks >= 300)
            begin
                drained = 1'b1;
                s_tvalid <= 1'b0;
                do
                    @(posedge clk);
                while (pending_states.size() != 0);
                @(negedge clk);
            end
            // receiver backs off for a long stretch while ticks keep coming
            if (!held && ticks >= 600)
            begin
                held          = 1'b1;
                long_hold_req = 1'b1;
            end
            send_tick(item, 1'b0, want);
        end

        // walk to decode, then halt and check that every later tick is frozen
        while (ctl_state != ST_DECODE)
        begin
            item              = '0;
            item.address_mode = 2'($urandom_range(0, 3));
            send_tick(item, 1'b0, want);
        end
        want.halted     = 1'b1;
        want.next_state = ST_DECODE;
        item.opcode        = OP_HLT;
        item.address_mode  = 2'($urandom_range(0, 3));
        item.flag_negative = 1'($urandom_range(0, 1));
        item.flag_zero     = 1'($urandom_range(0, 1));
        item.flag_carry    = 1'($urandom_range(0, 1));
        send_tick(item, 1'b1, want);
        repeat (FROZEN_TICKS)
        begin
            item = mcfsm_item_t'(ITEM_W'($urandom_range(0, (1 << ITEM_W) - 1)));
            send_tick(item, 1'b1, want);
        end

        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_states.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
